// ----- design/clint_pkg.sv -----
// ----------------------------------------------------------------------------
// clint_pkg
// Shared constants, codes and types of the core-local interrupt timer.
// ----------------------------------------------------------------------------
package clint_pkg;

    // Sizes of the design
    localparam int HARTS_BUILT = 4;
    localparam int HART_W      = (HARTS_BUILT > 1) ? $clog2(HARTS_BUILT) : 1;
    localparam int LINE_W      = 4;

    // Field widths
    localparam int OP_W    = 2;
    localparam int ADDR_W  = 16;
    localparam int DATA_W  = 32;
    localparam int SIZE_W  = 4;
    localparam int PRIV_W  = 2;
    localparam int HARTS_W = 3;
    localparam int TIME_W  = 64;

    // Register map bases
    localparam logic [ADDR_W-1:0] MSOFT_BASE = 16'd0;
    localparam logic [ADDR_W-1:0] MCMP_BASE  = 16'd16384;
    localparam logic [ADDR_W-1:0] SSOFT_BASE = 16'd49152;
    localparam logic [ADDR_W-1:0] SCMP_BASE  = 16'd53248;

    // Operation codes
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

    // Privilege codes
    localparam logic [PRIV_W-1:0] PRIV_SUPER   = 2'd1;
    localparam logic [PRIV_W-1:0] PRIV_MACHINE = 2'd3;

    // Only word accesses are taken
    localparam logic [SIZE_W-1:0] WORD_SIZE = 4'd4;

    // Harts in use after reset
    localparam logic [HARTS_W-1:0] HARTS_RESET = 3'd1;

    // One input word
    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
        logic [SIZE_W-1:0] access_size;
        logic [PRIV_W-1:0] privilege;
    } t_item;

    // One result word
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              access_error;
        logic [TIME_W-1:0] time_now;
        logic [LINE_W-1:0] machine_soft_lines;
        logic [LINE_W-1:0] super_soft_lines;
        logic [LINE_W-1:0] machine_timer_lines;
        logic [LINE_W-1:0] super_timer_lines;
    } t_result;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture the input word
        logic exec;      // decode, access and tick
        logic out_load;  // fill the output register
    } t_dp_cmd;

endpackage

// ----- design/clint_channels.sv -----
// ----------------------------------------------------------------------------
// clint channels
// Valid/ready channel interfaces for input words, result words and the
// hart count register.
// ----------------------------------------------------------------------------
interface clint_in_if;
    logic                            valid;
    logic                            ready;
    logic [clint_pkg::OP_W-1:0]      operation;
    logic [clint_pkg::ADDR_W-1:0]    address;
    logic [clint_pkg::DATA_W-1:0]    write_data;
    logic [clint_pkg::SIZE_W-1:0]    access_size;
    logic [clint_pkg::PRIV_W-1:0]    privilege;

    modport source (output valid, operation, address, write_data, access_size,
                    privilege, input ready);
    modport sink   (input valid, operation, address, write_data, access_size,
                    privilege, output ready);
endinterface

interface clint_out_if;
    logic                            valid;
    logic                            ready;
    logic [clint_pkg::DATA_W-1:0]    read_data;
    logic                            access_error;
    logic [clint_pkg::TIME_W-1:0]    time_now;
    logic [clint_pkg::LINE_W-1:0]    machine_soft_lines;
    logic [clint_pkg::LINE_W-1:0]    super_soft_lines;
    logic [clint_pkg::LINE_W-1:0]    machine_timer_lines;
    logic [clint_pkg::LINE_W-1:0]    super_timer_lines;

    modport source (output valid, read_data, access_error, time_now,
                    machine_soft_lines, super_soft_lines, machine_timer_lines,
                    super_timer_lines, input ready);
    modport sink   (input valid, read_data, access_error, time_now,
                    machine_soft_lines, super_soft_lines, machine_timer_lines,
                    super_timer_lines, output ready);
endinterface

interface clint_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [clint_pkg::HARTS_W-1:0]   harts_in_use;

    modport source (output valid, harts_in_use, input ready);
    modport sink   (input valid, harts_in_use, output ready);
endinterface

// ----- design/core_local_interrupt_timer_top.sv -----
// ----------------------------------------------------------------------------
// core_local_interrupt_timer_top
// Core-local interrupt controller with machine and supervisor timers.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one word per access: a time tick, a 32-bit register read
//   or a 32-bit register write. o_out returns one result word for each input
//   word: read data, error flag, the time counter and the per-hart software
//   and timer lines after the word. i_cfg writes the hart count register;
//   write it only while no word is in flight.
// Timing:
//   A word is captured, executed (decode, bank access, tick), then the line
//   compare fills the output register and raises the result valid. The
//   three-step sequencer takes no new word until the last one has left the
//   finish step.
// Reset:
//   Pending bits clear, compares load all ones, time clears, hart count
//   becomes one. The hart count port is always ready.
// Stall:
//   A waiting result sits in the output register while the next word is
//   accepted and executed; that word holds in the finish step until the
//   register is taken.
// ----------------------------------------------------------------------------
module core_local_interrupt_timer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    clint_in_if.sink    i_in,
    clint_out_if.source o_out,
    clint_cfg_if.sink   i_cfg
);
    import clint_pkg::*;

    t_dp_cmd cmd;
    t_item   item;
    t_result result;
    logic    in_ready;
    logic    out_valid;

    // Pack the input word
    assign item.operation   = i_in.operation;
    assign item.address     = i_in.address;
    assign item.write_data  = i_in.write_data;
    assign item.access_size = i_in.access_size;
    assign item.privilege   = i_in.privilege;

    clint_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    clint_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (item),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_harts (i_cfg.harts_in_use),
        .o_result    (result)
    );

    // Drive the channels
    assign i_in.ready                = in_ready;
    assign i_cfg.ready               = 1'b1;
    assign o_out.valid               = out_valid;
    assign o_out.read_data           = result.read_data;
    assign o_out.access_error        = result.access_error;
    assign o_out.time_now            = result.time_now;
    assign o_out.machine_soft_lines  = result.machine_soft_lines;
    assign o_out.super_soft_lines    = result.super_soft_lines;
    assign o_out.machine_timer_lines = result.machine_timer_lines;
    assign o_out.super_timer_lines   = result.super_timer_lines;

endmodule

// ----- design/clint_ctrl.sv -----
// ----------------------------------------------------------------------------
// clint_ctrl
// Sequencer: capture a word, run its access, then hand the result to the
// output register.
// ----------------------------------------------------------------------------
module clint_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output clint_pkg::t_dp_cmd o_cmd
);
    import clint_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state        = r_state;
        o_cmd.load     = 1'b0;
        o_cmd.exec     = 1'b0;
        o_cmd.out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output word valid: set on load, drop when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef ASSERT_OFF
    a_exec_then_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> (r_state == S_FINISH))
        else $error("exec not followed by finish");

    a_accept_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_cmd.exec)
        else $error("accepted word not executed");

    a_valid_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_FINISH))
        else $error("result raised outside finish");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("pending result overwritten");
`endif

endmodule

// ----- design/clint_dp.sv -----
// ----------------------------------------------------------------------------
// clint_dp
// Datapath: register banks, time counter, address decode and the
// interrupt line compare feeding the output register.
// ----------------------------------------------------------------------------
module clint_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  clint_pkg::t_dp_cmd              i_cmd,
    input  clint_pkg::t_item                i_item,
    input  logic                            i_cfg_valid,
    input  logic [clint_pkg::HARTS_W-1:0]   i_cfg_harts,
    output clint_pkg::t_result              o_result
);
    import clint_pkg::*;

    t_item              r_item;
    logic [HARTS_W-1:0] r_harts;
    logic [TIME_W-1:0]  r_time;
    logic [HARTS_BUILT-1:0] r_msp;
    logic [HARTS_BUILT-1:0] r_ssp;
    logic [TIME_W-1:0]  r_mcmp [HARTS_BUILT];
    logic [TIME_W-1:0]  r_scmp [HARTS_BUILT];
    logic [DATA_W-1:0]  r_rdata;
    logic               r_err;
    t_result            r_out;

    logic [HARTS_W-1:0] act_n;
    logic [16:0]        span4;
    logic [16:0]        span8;
    logic               hit_msoft;
    logic               hit_mcmp;
    logic               hit_ssoft;
    logic               hit_scmp;
    logic [ADDR_W-1:0]  off;
    logic [HART_W-1:0]  hart;
    logic               sup;
    logic               cmp;
    logic               upper;
    logic               hit;
    logic               ok;
    logic [TIME_W-1:0]  sel_cmp;
    logic [DATA_W-1:0]  n_rdata;
    logic [LINE_W-1:0]  act_mask;
    logic [LINE_W-1:0]  n_msl;
    logic [LINE_W-1:0]  n_ssl;
    logic [LINE_W-1:0]  n_mtl;
    logic [LINE_W-1:0]  n_stl;

    // Test an address against a bank of span bytes at base
    function automatic logic in_bank(input logic [ADDR_W-1:0] a,
                                     input logic [ADDR_W-1:0] base,
                                     input logic [16:0] span);
        logic [16:0] lim;
        lim     = {1'b0, base} + span;
        in_bank = (a >= base) && ({1'b0, a} < lim);
    endfunction

    // Clamp the hart count to the harts built
    assign act_n = (32'(r_harts) > HARTS_BUILT) ? HARTS_W'(HARTS_BUILT) : r_harts;
    assign span4 = {12'd0, act_n, 2'b00};
    assign span8 = {11'd0, act_n, 3'b000};

    // Decode banks in priority order
    assign hit_msoft = in_bank(r_item.address, MSOFT_BASE, span4);
    assign hit_mcmp  = in_bank(r_item.address, MCMP_BASE, span8);
    assign hit_ssoft = in_bank(r_item.address, SSOFT_BASE, span4);
    assign hit_scmp  = in_bank(r_item.address, SCMP_BASE, span8);

    always_comb begin
        off   = '0;
        sup   = 1'b0;
        cmp   = 1'b0;
        upper = 1'b0;
        hart  = '0;
        hit   = 1'b1;
        if (hit_msoft) begin
            off  = r_item.address - MSOFT_BASE;
            hart = off[HART_W+1:2];
        end else if (hit_mcmp) begin
            off   = r_item.address - MCMP_BASE;
            cmp   = 1'b1;
            upper = off[2];
            hart  = off[HART_W+2:3];
        end else if (hit_ssoft) begin
            off  = r_item.address - SSOFT_BASE;
            sup  = 1'b1;
            hart = off[HART_W+1:2];
        end else if (hit_scmp) begin
            off   = r_item.address - SCMP_BASE;
            sup   = 1'b1;
            cmp   = 1'b1;
            upper = off[2];
            hart  = off[HART_W+2:3];
        end else begin
            hit = 1'b0;
        end
    end

    // Check size, alignment, decode and privilege
    assign ok = (r_item.access_size == WORD_SIZE) && (r_item.address[1:0] == 2'b00)
              && hit && ((r_item.privilege == PRIV_MACHINE)
              || (sup && (r_item.privilege == PRIV_SUPER)));

    // Read mux
    assign sel_cmp = sup ? r_scmp[hart] : r_mcmp[hart];
    always_comb begin
        n_rdata = '0;
        if (ok && (r_item.operation == OP_READ)) begin
            if (!cmp) begin
                n_rdata = {31'd0, sup ? r_ssp[hart] : r_msp[hart]};
            end else begin
                n_rdata = upper ? sel_cmp[63:32] : sel_cmp[31:0];
            end
        end
    end

    // Capture the input word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
    end

    // Hold the hart count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_harts <= HARTS_RESET;
        end else if (i_cfg_valid) begin
            r_harts <= i_cfg_harts;
        end
    end

    // Advance time, apply writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
            r_msp  <= '0;
            r_ssp  <= '0;
            for (int i = 0; i < HARTS_BUILT; i++) begin
                r_mcmp[i] <= '1;
                r_scmp[i] <= '1;
            end
        end else if (i_cmd.exec) begin
            if (r_item.operation == OP_TICK) begin
                r_time <= r_time + 64'd1;
            end else if (ok && (r_item.operation == OP_WRITE)) begin
                if (!cmp && sup) begin
                    r_ssp[hart] <= r_item.write_data[0];
                end else if (!cmp) begin
                    r_msp[hart] <= r_item.write_data[0];
                end else if (sup && upper) begin
                    r_scmp[hart][63:32] <= r_item.write_data;
                end else if (sup) begin
                    r_scmp[hart][31:0] <= r_item.write_data;
                end else if (upper) begin
                    r_mcmp[hart][63:32] <= r_item.write_data;
                end else begin
                    r_mcmp[hart][31:0] <= r_item.write_data;
                end
            end
        end
    end

    // Hold the access result
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_rdata <= n_rdata;
            r_err   <= ((r_item.operation == OP_READ) ||
                        (r_item.operation == OP_WRITE)) && !ok;
        end
    end

    // Compare every hart against the time counter
    for (genvar g = 0; g < LINE_W; g++) begin : g_line
        assign act_mask[g] = (g < 32'(act_n));
        if (g < HARTS_BUILT) begin : g_hart
            assign n_msl[g] = act_mask[g] && r_msp[g];
            assign n_ssl[g] = act_mask[g] && r_ssp[g];
            assign n_mtl[g] = act_mask[g] && (r_mcmp[g] <= r_time);
            assign n_stl[g] = act_mask[g] && (r_scmp[g] <= r_time);
        end else begin : g_none
            assign n_msl[g] = 1'b0;
            assign n_ssl[g] = 1'b0;
            assign n_mtl[g] = 1'b0;
            assign n_stl[g] = 1'b0;
        end
    end

    // Fill the output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.read_data           <= r_rdata;
            r_out.access_error        <= r_err;
            r_out.time_now            <= r_time;
            r_out.machine_soft_lines  <= n_msl;
            r_out.super_soft_lines    <= n_ssl;
            r_out.machine_timer_lines <= n_mtl;
            r_out.super_timer_lines   <= n_stl;
        end
    end

    assign o_result = r_out;

`ifndef ASSERT_OFF
    a_tick_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && (r_item.operation == OP_TICK))
        |=> (r_time == $past(r_time) + 64'd1))
        else $error("tick did not advance time");

    a_err_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> (!r_out.access_error || (r_out.read_data == '0)))
        else $error("rejected access returned data");

    a_idle_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> (((r_out.machine_soft_lines | r_out.super_soft_lines
            | r_out.machine_timer_lines | r_out.super_timer_lines)
            & ~$past(act_mask)) == '0))
        else $error("inactive hart drives a line");
`endif

endmodule
